// File: src/wfpd_pkg.sv
// ----------------------------------------------------------------------------
// wfpd_pkg: shared types and constants of the wall follow stop detector
// widths, control word layout and the microprogram of the sequencer
// ----------------------------------------------------------------------------
package wfpd_pkg;

    // field and datapath widths
    localparam int RAW_W      = 12;
    localparam int FILT_W     = 20;
    localparam int ERR_W      = 21;
    localparam int DIFF_W     = 22;
    localparam int PER_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int ALPHA_W    = 9;
    localparam int MUL_A_W    = 21;
    localparam int MUL_B_W    = 20;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int LO_W       = 19;
    localparam int MHI_W      = 18;
    localparam int NUM_W      = 57;
    localparam int QUO_W      = 42;
    localparam int P_W        = 37;
    localparam int SUM_W      = 44;
    localparam int CORR_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PC_W       = 5;
    localparam int UCODE_LEN  = 19;

    // microseconds per second
    localparam logic [MUL_B_W-1:0] MEGA = 20'd1000000;

    // reset values of the registers
    localparam logic [RAW_W-1:0]   SIDE_THR_RST  = 12'd3667;
    localparam logic [RAW_W-1:0]   FRONT_THR_RST = 12'd4000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd102;
    localparam logic [GAIN_W-1:0]  PGAIN_RST     = 16'd6554;
    localparam logic [GAIN_W-1:0]  DGAIN_RST     = 16'd197;

    // fixed program steps
    localparam logic [PC_W-1:0] STEP_DIV_WAIT = 5'd16;
    localparam logic [PC_W-1:0] STEP_COMBINE  = 5'd17;
    localparam logic [PC_W-1:0] STEP_FINISH   = 5'd18;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIDE_THR   = 3'd0,
        CFG_FRONT_THR  = 3'd1,
        CFG_ALPHA      = 3'd2,
        CFG_PROP_GAIN  = 3'd3,
        CFG_DERIV_GAIN = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_FRONT = 2'd1,
        CAUSE_SIDE  = 2'd2
    } t_cause;

    // multiplier operand a
    typedef enum logic [2:0] {
        MA_ZERO, MA_ALPHA, MA_BETA, MA_ABS_E, MA_ABS_DIFF, MA_PROD_LO, MA_MHI
    } t_mul_a;

    // multiplier operand b
    typedef enum logic [2:0] {
        MB_ZERO, MB_RAW, MB_FILT, MB_PGAIN, MB_DGAIN, MB_MEGA
    } t_mul_b;

    // accumulator action on the registered product
    typedef enum logic [2:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD_WR, ACC_SAVE_P, ACC_SAVE_MHI, ACC_ADD_HI
    } t_acc;

    typedef enum logic [2:0] {
        OP_NONE, OP_EVAL, OP_DIFF, OP_DIV_START, OP_COMBINE, OP_FINISH
    } t_op;

    // jump condition, taken jump goes to target
    typedef enum logic [2:0] {
        CD_NEXT, CD_NO_PD, CD_PERIOD_ZERO, CD_DIV_BUSY, CD_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_mul_a          mul_a;
        t_mul_b          mul_b;
        logic [1:0]      mul_ch;
        t_acc            acc;
        logic [1:0]      wr_ch;
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uop;

    function automatic t_uop mk_uop(input t_mul_a a, input t_mul_b b,
                                    input logic [1:0] ch, input t_acc acc,
                                    input logic [1:0] wr, input t_op op,
                                    input t_cond cond, input logic [PC_W-1:0] tgt);
        t_uop u;
        u.mul_a  = a;
        u.mul_b  = b;
        u.mul_ch = ch;
        u.acc    = acc;
        u.wr_ch  = wr;
        u.op     = op;
        u.cond   = cond;
        u.target = tgt;
        return u;
    endfunction

    // microprogram: channels 0 left, 1 right, 2 front left, 3 front right
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // low-pass filters, two products per channel
            5'd0:  u = mk_uop(MA_ALPHA, MB_RAW, 2'd0, ACC_NONE, 2'd0, OP_NONE, CD_NEXT, '0);
            5'd1:  u = mk_uop(MA_BETA, MB_FILT, 2'd0, ACC_LOAD, 2'd0, OP_NONE, CD_NEXT, '0);
            5'd2:  u = mk_uop(MA_ALPHA, MB_RAW, 2'd1, ACC_ADD_WR, 2'd0, OP_NONE, CD_NEXT, '0);
            5'd3:  u = mk_uop(MA_BETA, MB_FILT, 2'd1, ACC_LOAD, 2'd0, OP_NONE, CD_NEXT, '0);
            5'd4:  u = mk_uop(MA_ALPHA, MB_RAW, 2'd2, ACC_ADD_WR, 2'd1, OP_NONE, CD_NEXT, '0);
            5'd5:  u = mk_uop(MA_BETA, MB_FILT, 2'd2, ACC_LOAD, 2'd0, OP_NONE, CD_NEXT, '0);
            5'd6:  u = mk_uop(MA_ALPHA, MB_RAW, 2'd3, ACC_ADD_WR, 2'd2, OP_NONE, CD_NEXT, '0);
            5'd7:  u = mk_uop(MA_BETA, MB_FILT, 2'd3, ACC_LOAD, 2'd0, OP_NONE, CD_NEXT, '0);
            5'd8:  u = mk_uop(MA_ZERO, MB_ZERO, 2'd0, ACC_ADD_WR, 2'd3, OP_NONE, CD_NEXT, '0);
            // wall tests and error, skip the pd terms on a stop or no wall
            5'd9:  u = mk_uop(MA_ZERO, MB_ZERO, 2'd0, ACC_NONE, 2'd0, OP_EVAL, CD_NO_PD,
                              STEP_FINISH);
            // proportional product, error difference
            5'd10: u = mk_uop(MA_ABS_E, MB_PGAIN, 2'd0, ACC_NONE, 2'd0, OP_DIFF, CD_NEXT, '0);
            5'd11: u = mk_uop(MA_ABS_DIFF, MB_DGAIN, 2'd0, ACC_SAVE_P, 2'd0, OP_NONE,
                              CD_NEXT, '0);
            // derivative numerator times one million in two partial products
            5'd12: u = mk_uop(MA_PROD_LO, MB_MEGA, 2'd0, ACC_SAVE_MHI, 2'd0, OP_NONE,
                              CD_NEXT, '0);
            5'd13: u = mk_uop(MA_MHI, MB_MEGA, 2'd0, ACC_LOAD, 2'd0, OP_NONE, CD_NEXT, '0);
            5'd14: u = mk_uop(MA_ZERO, MB_ZERO, 2'd0, ACC_ADD_HI, 2'd0, OP_NONE,
                              CD_PERIOD_ZERO, STEP_COMBINE);
            // divide by the sample period
            5'd15: u = mk_uop(MA_ZERO, MB_ZERO, 2'd0, ACC_NONE, 2'd0, OP_DIV_START,
                              CD_NEXT, '0);
            5'd16: u = mk_uop(MA_ZERO, MB_ZERO, 2'd0, ACC_NONE, 2'd0, OP_NONE,
                              CD_DIV_BUSY, STEP_DIV_WAIT);
            5'd17: u = mk_uop(MA_ZERO, MB_ZERO, 2'd0, ACC_NONE, 2'd0, OP_COMBINE,
                              CD_NEXT, '0);
            5'd18: u = mk_uop(MA_ZERO, MB_ZERO, 2'd0, ACC_NONE, 2'd0, OP_FINISH,
                              CD_OUT_BUSY, STEP_FINISH);
            default: u = mk_uop(MA_ZERO, MB_ZERO, 2'd0, ACC_NONE, 2'd0, OP_FINISH,
                                CD_OUT_BUSY, STEP_FINISH);
        endcase
        return u;
    endfunction

endpackage

// File: src/wfpd_div.sv
// ----------------------------------------------------------------------------
// wfpd_div: radix-4 restoring divider for the derivative term
// unsigned quotient of a 57-bit numerator by a 16-bit period, two bits a
// cycle; a quotient that would not fit in 42 bits returns all ones at once
// ----------------------------------------------------------------------------
module wfpd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wfpd_pkg::NUM_W-1:0]  i_num,
    input  logic [wfpd_pkg::PER_W-1:0]  i_div,
    output logic                        o_busy,
    output logic [wfpd_pkg::QUO_W-1:0]  o_quo
);
    import wfpd_pkg::*;

    localparam int HEAD_W = NUM_W - QUO_W;
    localparam int ITER   = QUO_W / 2;
    localparam int CNT_W  = $clog2(ITER);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [PER_W-1:0] r_rem;
    logic [PER_W-1:0] r_div;
    logic [QUO_W-1:0] r_shift;

    logic [PER_W:0]   t1, t2, dv;
    logic             ge1, ge2;
    logic [PER_W-1:0] rem1, rem2;
    logic             ovf;

    // two dependent subtract steps per cycle
    always_comb begin
        dv   = {1'b0, r_div};
        t1   = {r_rem, r_shift[QUO_W-1]};
        ge1  = t1 >= dv;
        rem1 = ge1 ? PER_W'(t1 - dv) : t1[PER_W-1:0];
        t2   = {rem1, r_shift[QUO_W-2]};
        ge2  = t2 >= dv;
        rem2 = ge2 ? PER_W'(t2 - dv) : t2[PER_W-1:0];
        ovf  = {{(PER_W-HEAD_W){1'b0}}, i_num[NUM_W-1:QUO_W]} >= i_div;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !ovf;
            r_cnt  <= CNT_W'(ITER - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // datapath: numerator bits shift out the top, quotient bits in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            if (ovf) begin
                r_shift <= '1;
                r_rem   <= '0;
            end else begin
                r_shift <= i_num[QUO_W-1:0];
                r_rem   <= {{(PER_W-HEAD_W){1'b0}}, i_num[NUM_W-1:QUO_W]};
            end
        end else if (r_busy) begin
            r_shift <= {r_shift[QUO_W-3:0], ge1, ge2};
            r_rem   <= rem2;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_shift;

    // checks
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0) |=> !r_busy)
        else $error("divider ran past its last step");

endmodule

// File: src/wall_follow_pd_stop_detector_top.sv
// ----------------------------------------------------------------------------
// wall_follow_pd_stop_detector_top: wall centering pd with stop detection
// filters four ir readings, stops at a front wall or side wall edge, else
// computes a saturated pd centering correction; microcoded datapath
// ----------------------------------------------------------------------------
//  channel   direction  signals                            content
//  s_axis    in         tvalid tready tdata[63:0] tuser    one sample of four ir readings
//  m_axis    out        tvalid tready tdata[31:0] tlast    correction, cause and wall flags
//  cfg       in         i_cfg_we i_cfg_idx i_cfg_data      register write, no read-back
//
//  a stop or a sample with no wall skips the pd steps, a zero period skips the
//  radix-4 divider, and the full pd path runs the divider to its last step
//  one sample is in flight at a time; the next is taken while a result waits
//  in the output register, which stalls only the last program step
//  synchronous active-low reset restores register defaults and clears state
// ----------------------------------------------------------------------------
module wall_follow_pd_stop_detector_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // ir_left, ir_right, ir_front_left, ir_front_right, sample_period_us
    input  logic [63:0]                      s_axis_tdata,
    // restart
    input  logic                             s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // correction, stop_cause, left_wall_seen, right_wall_seen, zero fill
    output logic [31:0]                      m_axis_tdata,
    // stop_now
    output logic                             m_axis_tlast,
    // register writes
    input  logic                             i_cfg_we,
    input  logic [wfpd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wfpd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wfpd_pkg::*;

    // configuration
    logic [RAW_W-1:0]   r_side_thr, r_front_thr;
    logic [ALPHA_W-1:0] r_alpha;
    logic [GAIN_W-1:0]  r_pgain, r_dgain;

    // item and move state
    logic [RAW_W-1:0]   r_raw [4];
    logic [PER_W-1:0]   r_period;
    logic [FILT_W-1:0]  r_filt [4];
    logic signed [ERR_W-1:0]  r_prev_err;
    logic               r_lwb, r_rwb, r_active;

    // sequencer
    logic               r_busy;
    logic [PC_W-1:0]    r_pc;
    t_uop               uw;

    // datapath
    logic [PROD_W-1:0]  r_prod;
    logic [NUM_W-1:0]   r_acc;
    logic signed [P_W-1:0]    r_p;
    logic [MHI_W-1:0]   r_mhi;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic               r_lw, r_rw;
    t_cause             r_cause;
    logic [CORR_W-1:0]  r_corr;

    // output register
    logic               r_out_valid, r_out_last, r_out_lw, r_out_rw;
    logic [1:0]         r_out_cause;
    logic [CORR_W-1:0]  r_out_corr;

    logic               s_acc, m_acc, out_free, jump, div_busy, div_start;
    logic [QUO_W-1:0]   div_quo;
    logic [ALPHA_W-1:0] alpha_c, beta;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_A_W-1:0] abs_e, abs_diff;
    logic [28:0]        filt_sum;
    logic [FILT_W-1:0]  side_t, front_t, e_min, e_sub;
    logic               lw, rw, front_hit, edge_hit, pd_go;
    logic signed [ERR_W-1:0]  e_new;
    logic signed [QUO_W:0]    d_s;
    logic signed [SUM_W-1:0]  pd_sum;
    logic [CORR_W-1:0]  corr_sat;

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_acc         = m_axis_tvalid && m_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_busy;
    assign uw            = ucode(r_pc);
    assign div_start     = r_busy && (uw.op == OP_DIV_START);

    // weight of the new sample, above one acts as one
    assign alpha_c = r_alpha[ALPHA_W-1] ? 9'd256 : r_alpha;
    assign beta    = 9'd256 - alpha_c;

    // magnitudes for the unsigned multiplier
    always_comb begin
        abs_e    = r_err[ERR_W-1] ? MUL_A_W'(-r_err) : MUL_A_W'(r_err);
        abs_diff = r_diff[DIFF_W-1] ? MUL_A_W'(-r_diff) : MUL_A_W'(r_diff);
    end

    // shared multiplier operand select
    always_comb begin
        case (uw.mul_a)
            MA_ALPHA:    mul_a = {12'd0, alpha_c};
            MA_BETA:     mul_a = {12'd0, beta};
            MA_ABS_E:    mul_a = abs_e;
            MA_ABS_DIFF: mul_a = abs_diff;
            MA_PROD_LO:  mul_a = {2'd0, r_prod[LO_W-1:0]};
            MA_MHI:      mul_a = {3'd0, r_mhi};
            default:     mul_a = '0;
        endcase
        case (uw.mul_b)
            MB_RAW:   mul_b = {r_raw[uw.mul_ch], 8'd0};
            MB_FILT:  mul_b = r_filt[uw.mul_ch];
            MB_PGAIN: mul_b = {4'd0, r_pgain};
            MB_DGAIN: mul_b = {4'd0, r_dgain};
            MB_MEGA:  mul_b = MEGA;
            default:  mul_b = '0;
        endcase
    end

    assign filt_sum = r_acc[28:0] + r_prod[28:0];

    // wall tests and centering error
    always_comb begin
        side_t    = {r_side_thr, 8'd0};
        front_t   = {r_front_thr, 8'd0};
        lw        = r_filt[0] > side_t;
        rw        = r_filt[1] > side_t;
        front_hit = (r_filt[2] > front_t) || (r_filt[3] > front_t);
        edge_hit  = (r_lwb && !lw) || (r_rwb && !rw);
        pd_go     = !front_hit && !edge_hit && (lw || rw);
        if (lw && rw) begin
            e_min = r_filt[1];
            e_sub = r_filt[0];
        end else if (rw) begin
            e_min = r_filt[1];
            e_sub = side_t;
        end else begin
            e_min = side_t;
            e_sub = r_filt[0];
        end
        e_new = $signed({1'b0, e_min}) - $signed({1'b0, e_sub});
    end

    // p plus truncated d, floor by 2^16, saturate
    always_comb begin
        if (r_period == '0) begin
            d_s = '0;
        end else if (r_diff[DIFF_W-1]) begin
            d_s = -$signed({1'b0, div_quo});
        end else begin
            d_s = $signed({1'b0, div_quo});
        end
        pd_sum = $signed({{(SUM_W-P_W){r_p[P_W-1]}}, r_p})
               + $signed({d_s[QUO_W], d_s});
        if (pd_sum[SUM_W-1:39] == '0 || pd_sum[SUM_W-1:39] == '1) begin
            corr_sat = pd_sum[39:16];
        end else if (pd_sum[SUM_W-1]) begin
            corr_sat = {1'b1, {(CORR_W-1){1'b0}}};
        end else begin
            corr_sat = {1'b0, {(CORR_W-1){1'b1}}};
        end
    end

    // jump condition
    always_comb begin
        case (uw.cond)
            CD_NO_PD:       jump = !pd_go;
            CD_PERIOD_ZERO: jump = (r_period == '0);
            CD_DIV_BUSY:    jump = div_busy;
            CD_OUT_BUSY:    jump = !out_free;
            default:        jump = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_thr  <= SIDE_THR_RST;
            r_front_thr <= FRONT_THR_RST;
            r_alpha     <= ALPHA_RST;
            r_pgain     <= PGAIN_RST;
            r_dgain     <= DGAIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SIDE_THR:   r_side_thr  <= i_cfg_data[RAW_W-1:0];
                CFG_FRONT_THR:  r_front_thr <= i_cfg_data[RAW_W-1:0];
                CFG_ALPHA:      r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                CFG_PROP_GAIN:  r_pgain     <= i_cfg_data;
                CFG_DERIV_GAIN: r_dgain     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (s_acc) begin
            r_busy <= 1'b1;
            r_pc   <= '0;
        end else if (r_busy) begin
            if (jump) begin
                r_pc <= uw.target;
            end else if (uw.op == OP_FINISH) begin
                r_busy <= 1'b0;
                r_pc   <= '0;
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    // move state: filters, previous error, wall flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt[0]  <= '0;
            r_filt[1]  <= '0;
            r_filt[2]  <= '0;
            r_filt[3]  <= '0;
            r_prev_err <= '0;
            r_lwb      <= 1'b0;
            r_rwb      <= 1'b0;
            r_active   <= 1'b0;
        end else if (s_acc) begin
            // new move clears front filters and history
            if (s_axis_tuser || !r_active) begin
                r_filt[2]  <= '0;
                r_filt[3]  <= '0;
                r_prev_err <= '0;
                r_lwb      <= 1'b0;
                r_rwb      <= 1'b0;
                r_active   <= 1'b1;
            end
        end else if (r_busy) begin
            if (uw.acc == ACC_ADD_WR) begin
                r_filt[uw.wr_ch] <= filt_sum[27:8];
            end
            if (uw.op == OP_EVAL) begin
                if (front_hit) begin
                    r_active <= 1'b0;
                end else if (edge_hit) begin
                    r_lwb    <= 1'b0;
                    r_rwb    <= 1'b0;
                    r_active <= 1'b0;
                end else begin
                    r_lwb <= lw;
                    r_rwb <= rw;
                end
            end
            if (uw.op == OP_DIFF) begin
                r_prev_err <= r_err;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_raw[0] <= s_axis_tdata[11:0];
            r_raw[1] <= s_axis_tdata[23:12];
            r_raw[2] <= s_axis_tdata[35:24];
            r_raw[3] <= s_axis_tdata[47:36];
            r_period <= s_axis_tdata[63:48];
        end
        r_prod <= mul_a * mul_b;
        case (uw.acc)
            ACC_LOAD:     r_acc <= {{(NUM_W-PROD_W){1'b0}}, r_prod};
            ACC_ADD_HI:   r_acc <= r_acc + {r_prod[37:0], {LO_W{1'b0}}};
            ACC_SAVE_P: begin
                if (r_err[ERR_W-1]) begin
                    r_p <= -$signed({1'b0, r_prod[35:0]});
                end else begin
                    r_p <= $signed({1'b0, r_prod[35:0]});
                end
            end
            ACC_SAVE_MHI: r_mhi <= r_prod[LO_W+MHI_W-1:LO_W];
            default: ;
        endcase
        case (uw.op)
            OP_EVAL: begin
                r_lw   <= lw;
                r_rw   <= rw;
                r_err  <= e_new;
                r_corr <= '0;
                if (front_hit) begin
                    r_cause <= CAUSE_FRONT;
                end else if (edge_hit) begin
                    r_cause <= CAUSE_SIDE;
                end else begin
                    r_cause <= CAUSE_NONE;
                end
            end
            OP_DIFF:    r_diff <= DIFF_W'(r_err) - DIFF_W'(r_prev_err);
            OP_COMBINE: r_corr <= corr_sat;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_busy && uw.op == OP_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && uw.op == OP_FINISH && out_free) begin
            r_out_corr  <= r_corr;
            r_out_last  <= (r_cause != CAUSE_NONE);
            r_out_cause <= r_cause;
            r_out_lw    <= r_lw;
            r_out_rw    <= r_rw;
        end
    end

    wfpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_div   (r_period),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'd0, r_out_rw, r_out_lw, r_out_cause, r_out_corr};

    // checks
    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_busy && r_pc == '0))
        else $error("sample accepted without program start");

    a_pc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc < PC_W'(UCODE_LEN)))
        else $error("step counter outside the program");

    a_stop_ends_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && uw.op == OP_FINISH && out_free && r_cause != CAUSE_NONE)
        |=> !r_active)
        else $error("move still active after a stop");

    a_last_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[25:24] != CAUSE_NONE))
        else $error("stop result without a cause");

endmodule

// File: tb/wall_follow_pd_stop_detector_top_tb.sv
// ----------------------------------------------------------------------------
// wall_follow_pd_stop_detector_top_tb: self-checking bench of the centering pd
// drives ir samples on the input stream under random idling and back-pressure
// and checks each result field by field against a cycle-free model of the
// filters, the stop decisions and the saturated pd correction
// ----------------------------------------------------------------------------
module wall_follow_pd_stop_detector_top_tb;

    import wfpd_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int RX_HOLD_CYCLES  = 200;
    localparam int SETTLE_CYCLES   = 60;
    localparam int MAX_PRINTED     = 50;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // how a generated move comes to an end
    localparam int END_NONE      = 0;
    localparam int END_FRONT     = 1;
    localparam int END_WALL_LOST = 2;

    typedef struct {
        logic [RAW_W-1:0] ir_left;
        logic [RAW_W-1:0] ir_right;
        logic [RAW_W-1:0] ir_front_left;
        logic [RAW_W-1:0] ir_front_right;
        logic [PER_W-1:0] period_us;
        logic             restart;
    } t_ir_sample;

    typedef struct {
        logic [CORR_W-1:0] correction;
        logic              stop_now;
        t_cause            stop_cause;
        logic              left_seen;
        logic              right_seen;
    } t_pd_result;

    // model of the controller and store of the results it still owes
    class centering_scoreboard;
        logic [RAW_W-1:0]   side_thr;
        logic [RAW_W-1:0]   front_thr;
        logic [ALPHA_W-1:0] alpha;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [FILT_W-1:0]  left_avg;
        logic [FILT_W-1:0]  right_avg;
        logic [FILT_W-1:0]  front_left_avg;
        logic [FILT_W-1:0]  front_right_avg;
        longint             last_error;
        bit                 left_was_seen;
        bit                 right_was_seen;
        bit                 in_move;
        t_pd_result         pending_results[$];
        int                 mismatches;

        function new();
            side_thr        = SIDE_THR_RST;
            front_thr       = FRONT_THR_RST;
            alpha           = ALPHA_RST;
            prop_gain       = PGAIN_RST;
            deriv_gain      = DGAIN_RST;
            left_avg        = '0;
            right_avg       = '0;
            front_left_avg  = '0;
            front_right_avg = '0;
            last_error      = 0;
            left_was_seen   = 1'b0;
            right_was_seen  = 1'b0;
            in_move         = 1'b0;
            mismatches      = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SIDE_THR:   side_thr   = data[RAW_W-1:0];
                CFG_FRONT_THR:  front_thr  = data[RAW_W-1:0];
                CFG_ALPHA:      alpha      = data[ALPHA_W-1:0];
                CFG_PROP_GAIN:  prop_gain  = data;
                CFG_DERIV_GAIN: deriv_gain = data;
                default: ;
            endcase
        endfunction

        // exponential low-pass, weights above one act as one
        function logic [FILT_W-1:0] smooth(input logic [FILT_W-1:0] prior,
                                           input logic [RAW_W-1:0] raw);
            longint a, x, f, acc;
            a = alpha;
            if (a > 256)
                a = 256;
            x = raw;
            f = prior;
            acc = (a * (x << 8) + (256 - a) * f) >> 8;
            return acc[FILT_W-1:0];
        endfunction

        function void note_sample(input t_ir_sample s);
            t_pd_result r;
            longint side_q, front_q, lf, rf, flf, frf;
            longint e, p, d, sum, pg, dg, per;
            bit lw, rw;
            // a new move clears the front filters, error and wall flags
            if (s.restart || !in_move) begin
                front_left_avg  = '0;
                front_right_avg = '0;
                last_error      = 0;
                left_was_seen   = 1'b0;
                right_was_seen  = 1'b0;
                in_move         = 1'b1;
            end
            left_avg        = smooth(left_avg, s.ir_left);
            right_avg       = smooth(right_avg, s.ir_right);
            front_left_avg  = smooth(front_left_avg, s.ir_front_left);
            front_right_avg = smooth(front_right_avg, s.ir_front_right);
            side_q  = side_thr;
            side_q  = side_q << 8;
            front_q = front_thr;
            front_q = front_q << 8;
            lf  = left_avg;
            rf  = right_avg;
            flf = front_left_avg;
            frf = front_right_avg;
            lw  = lf > side_q;
            rw  = rf > side_q;
            r.correction = '0;
            r.stop_now   = 1'b0;
            r.stop_cause = CAUSE_NONE;
            if (flf > front_q || frf > front_q) begin
                // front wall wins over a side edge, flags stay
                r.stop_now   = 1'b1;
                r.stop_cause = CAUSE_FRONT;
                in_move      = 1'b0;
            end else if ((left_was_seen && !lw) || (right_was_seen && !rw)) begin
                r.stop_now     = 1'b1;
                r.stop_cause   = CAUSE_SIDE;
                left_was_seen  = 1'b0;
                right_was_seen = 1'b0;
                in_move        = 1'b0;
            end else begin
                left_was_seen  = lw;
                right_was_seen = rw;
                if (lw || rw) begin
                    if (lw && rw)
                        e = rf - lf;
                    else if (rw)
                        e = rf - side_q;
                    else
                        e = side_q - lf;
                    pg  = prop_gain;
                    dg  = deriv_gain;
                    per = s.period_us;
                    p   = pg * e;
                    d   = 0;
                    if (per != 0)
                        d = (dg * (e - last_error) * 1000000) / per;
                    // floor by arithmetic shift, then clamp to q16.8
                    sum = (p + d) >>> 16;
                    if (sum > 8388607)
                        sum = 8388607;
                    if (sum < -8388608)
                        sum = -8388608;
                    r.correction = sum[CORR_W-1:0];
                    last_error   = e;
                end
            end
            r.left_seen  = lw;
            r.right_seen = rw;
            pending_results.push_back(r);
        endfunction

        task report(input string field, input longint got, input longint want);
            if (mismatches < MAX_PRINTED)
                $display("mismatch on %s: got %0d, expected %0d", field, got, want);
            mismatches++;
        endtask

        task check_result(input logic [31:0] data, input logic last);
            t_pd_result want;
            longint got_corr, want_corr;
            if (pending_results.size() == 0) begin
                report("result with none pending", data, 0);
                return;
            end
            want = pending_results.pop_front();
            got_corr  = $signed(data[CORR_W-1:0]);
            want_corr = $signed(want.correction);
            if (data[CORR_W-1:0] !== want.correction)
                report("correction", got_corr, want_corr);
            if (last !== want.stop_now)
                report("stop_now", last, want.stop_now);
            if (data[25:24] !== want.stop_cause)
                report("stop_cause", data[25:24], want.stop_cause);
            if (data[26] !== want.left_seen)
                report("left_wall_seen", data[26], want.left_seen);
            if (data[27] !== want.right_seen)
                report("right_wall_seen", data[27], want.right_seen);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    centering_scoreboard book = new();
    bit tx_burst;
    bit rx_hold_req;
    int cycle_count;

    wall_follow_pd_stop_detector_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata, m_axis_tlast);
    end

    // receiver: random ready, one long hold-off on request
    initial begin
        int pick, n;
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(99, 0);
                if (pick < 50) begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(8, 1);
                end else if (pick < 80) begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(3, 1);
                end else if (pick < 92) begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(12, 4);
                end else if (pick < 96) begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(40, 20);
                end else begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(80, 30);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function automatic int tx_gap();
        int pick;
        if (tx_burst)
            return 0;
        pick = $urandom_range(99, 0);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(3, 1);
        if (pick < 95)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic t_ir_sample sample_of(input logic [RAW_W-1:0] l, r, fl, fr,
                                             input logic [PER_W-1:0] per,
                                             input logic rst);
        t_ir_sample s;
        s.ir_left        = l;
        s.ir_right       = r;
        s.ir_front_left  = fl;
        s.ir_front_right = fr;
        s.period_us      = per;
        s.restart        = rst;
        return s;
    endfunction

    function automatic logic [RAW_W-1:0] side_reading(input bit present);
        int thr;
        thr = book.side_thr;
        if (present)
            return RAW_W'($urandom_range(4095, thr));
        return RAW_W'($urandom_range(thr, 0));
    endfunction

    function automatic logic [RAW_W-1:0] front_reading(input bit near);
        int thr;
        thr = book.front_thr;
        if (near)
            return RAW_W'($urandom_range(4095, thr));
        return RAW_W'($urandom_range(thr * 3 / 4, 0));
    endfunction

    function automatic logic [PER_W-1:0] sample_period();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 15)
            return '0;
        if (pick < 25)
            return PER_W'($urandom_range(4, 1));
        if (pick < 45)
            return PER_W'($urandom_range(100, 5));
        if (pick < 80)
            return PER_W'($urandom_range(2000, 500));
        return PER_W'($urandom);
    endfunction

    // one request on the input stream, valid stays high across back-to-back items
    task automatic send_sample(input t_ir_sample s);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.period_us, s.ir_front_right, s.ir_front_left,
                          s.ir_right, s.ir_left};
        s_axis_tuser  <= s.restart;
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_sample(s);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (book.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        book.write_reg(idx, data);
    endtask

    // all five registers plus a write to an index that has none
    task automatic write_regs(input logic [CFG_DATA_W-1:0] side, front, alpha,
                              input logic [CFG_DATA_W-1:0] pgain, dgain);
        cfg_write(CFG_SIDE_THR, side);
        cfg_write(CFG_FRONT_THR, front);
        cfg_write(CFG_ALPHA, alpha);
        cfg_write(CFG_PROP_GAIN, pgain);
        cfg_write(CFG_DERIV_GAIN, dgain);
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // straight moves with random content, ending at a front wall, a lost wall
    // or running on; about one item in ten is pure noise
    task automatic run_moves(input int count);
        int sent, len, k, ending;
        bit want_left, want_right, closing;
        t_ir_sample s;
        sent = 0;
        while (sent < count) begin
            len        = $urandom_range(24, 2);
            want_left  = ($urandom_range(3, 0) != 0);
            want_right = ($urandom_range(3, 0) != 0);
            ending     = $urandom_range(END_WALL_LOST, END_NONE);
            tx_burst   = ($urandom_range(4, 0) == 0);
            for (k = 0; k < len && sent < count; k++) begin
                closing = (k >= len - 3);
                if ($urandom_range(9, 0) == 0) begin
                    s = sample_of(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                                  RAW_W'($urandom), PER_W'($urandom), 1'($urandom));
                end else begin
                    s.restart   = (k == 0) && ($urandom_range(3, 0) != 0);
                    s.ir_left   = side_reading(want_left &&
                                               !(closing && ending == END_WALL_LOST));
                    s.ir_right  = side_reading(want_right &&
                                               !(closing && ending == END_WALL_LOST &&
                                                 $urandom_range(1, 0)));
                    s.ir_front_left  = front_reading(closing && ending == END_FRONT &&
                                                     $urandom_range(1, 0));
                    s.ir_front_right = front_reading(closing && ending == END_FRONT &&
                                                     $urandom_range(1, 0));
                    s.period_us = sample_period();
                end
                send_sample(s);
                sent++;
            end
        end
        tx_burst = 1'b0;
    endtask

    // main sequence
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_SIDE_THR;
        i_cfg_data    <= '0;
        tx_burst      = 1'b0;
        rx_hold_req   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: all zero and all ones
        send_sample(sample_of(12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0));
        send_sample(sample_of(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1));
        drain_results();

        // unit weight so the filters follow the raw readings
        write_regs(16'd2000, 16'd3000, 16'd256, 16'd40000, 16'd3000);
        send_sample(sample_of(12'd0, 12'd0, 12'd0, 12'd0, 16'd100, 1'b0));
        send_sample(sample_of(12'd3000, 12'd2500, 12'd0, 12'd0, 16'd1000, 1'b1));
        // zero period, then shortest period
        send_sample(sample_of(12'd3000, 12'd2600, 12'd0, 12'd0, 16'd0, 1'b0));
        send_sample(sample_of(12'd3000, 12'd2700, 12'd0, 12'd0, 16'd1, 1'b0));
        // right wall only, then it vanishes
        send_sample(sample_of(12'd1000, 12'd3000, 12'd0, 12'd0, 16'd500, 1'b1));
        send_sample(sample_of(12'd1000, 12'd2500, 12'd0, 12'd0, 16'd500, 1'b0));
        send_sample(sample_of(12'd1000, 12'd1000, 12'd0, 12'd0, 16'd500, 1'b0));
        // left wall only on an idle block, then a front wall
        send_sample(sample_of(12'd3000, 12'd1000, 12'd0, 12'd0, 16'd700, 1'b0));
        send_sample(sample_of(12'd3000, 12'd1000, 12'd3500, 12'd0, 16'd700, 1'b0));
        // front wall together with a lost side wall
        send_sample(sample_of(12'd3000, 12'd3000, 12'd0, 12'd0, 16'd800, 1'b1));
        send_sample(sample_of(12'd1000, 12'd3000, 12'd0, 12'd4095, 16'd800, 1'b0));
        // front readings at the threshold do not stop
        send_sample(sample_of(12'd4095, 12'd0, 12'd0, 12'd0, 16'hFFFF, 1'b1));
        send_sample(sample_of(12'd4095, 12'd4095, 12'd3000, 12'd3000, 16'hFFFF, 1'b0));
        send_sample(sample_of(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1));
        drain_results();

        // weight above one, full gains: correction saturates both ways
        write_regs(16'd2000, 16'd3000, 16'h01FF, 16'hFFFF, 16'hFFFF);
        send_sample(sample_of(12'd0, 12'd4095, 12'd0, 12'd0, 16'd1, 1'b1));
        send_sample(sample_of(12'd0, 12'd2001, 12'd0, 12'd0, 16'd1, 1'b0));
        drain_results();

        // reset values, with one pause until every result is back
        write_regs(SIDE_THR_RST, FRONT_THR_RST, ALPHA_RST, PGAIN_RST, DGAIN_RST);
        run_moves(40);
        drain_results();
        run_moves(40);
        drain_results();

        // lowest side threshold, highest front threshold, full gains;
        // the receiver holds off while the input backs up
        write_regs(16'd0, 16'hFFFF, 16'd256, 16'hFFFF, 16'hFFFF);
        rx_hold_req = 1'b1;
        run_moves(60);
        drain_results();

        // the other extremes: frozen filters, zero gains
        write_regs(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        run_moves(20);
        drain_results();

        // slow filter
        write_regs(CFG_DATA_W'($urandom_range(3500, 1000)), 16'd4095, 16'd3,
                   16'd30000, 16'd5000);
        run_moves(40);
        drain_results();

        // random settings
        repeat (5) begin
            write_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                       CFG_DATA_W'($urandom));
            run_moves(40);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
src/wfpd_pkg.sv
src/wfpd_div.sv
src/wall_follow_pd_stop_detector_top.sv
tb/wall_follow_pd_stop_detector_top_tb.sv
